FILE: sv/chained_hash_table_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash table engine
// Checks are compiled only when SYNTHESIS is not defined.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH
`define CHAINED_HASH_TABLE_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CHTE_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("chte check failed");
`define CHTE_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("chte forbidden condition");
`else
`define CHTE_ASSERT(lbl, clk, rstn, prop)
`define CHTE_NEVER(lbl, clk, rstn, expr)
`endif

`endif

FILE: sv/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types, constants and key helpers of the hash table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package chte_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 32;
	localparam int ACT_W = 2;
	localparam int CNT_W = 11;
	localparam int KB_W  = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [KEY_W-1:0] FNV_START = 64'hCBF2_9CE4_8422_2325;
	// FNV prime = 2^40 + 0x1B3
	localparam int               FNV_SHIFT = 40;
	localparam logic [8:0]       FNV_LOW   = 9'h1B3;

	typedef enum logic [ACT_W-1:0] {
		ACT_SET  = 2'd0,
		ACT_GET  = 2'd1,
		ACT_POP  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUCKET_COUNT = 1'b0,
		REG_KEY_BYTES    = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		action_t           action;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} chte_req_t;

	function automatic logic [3:0] bytes_in_use(input logic [KB_W-1:0] kb);
		logic [3:0] n;
		if (kb == '0)
			n = 4'd1;
		else if (kb > 4'd8)
			n = 4'd8;
		else
			n = kb;
		return n;
	endfunction

	function automatic logic [KEY_W-1:0] key_mask(input logic [KB_W-1:0] kb);
		logic [3:0]       n;
		logic [KEY_W-1:0] m;
		n = bytes_in_use(kb);
		m = '1;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) >= n)
				m[i*8 +: 8] = 8'h00;
		end
		return m;
	endfunction

endpackage

FILE: sv/chte_ram.sv
// ----------------------------------------------------------------------------
// chte_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/chte_fifo.sv
// ----------------------------------------------------------------------------
// chte_fifo
// Small request queue between the hashing front end and the chain walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chte_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != (PW+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: sv/chte_front.sv
// ----------------------------------------------------------------------------
// chte_front
// Accepts requests, runs FNV-1 over the key bytes (one byte per cycle) and
// reduces the hash modulo the bucket count (four quotient bits per cycle).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chte_front #(
	parameter int BUCKETS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [chte_pkg::ACT_W-1:0]         action,
	input  logic [chte_pkg::KEY_W-1:0]         key,
	input  logic [chte_pkg::VAL_W-1:0]         value,
	input  logic [chte_pkg::CNT_W-1:0]         bucket_count,
	input  logic [chte_pkg::KB_W-1:0]          key_bytes,
	input  logic                               table_busy,
	output logic                               req_valid,
	input  logic                               req_ready,
	output chte_pkg::chte_req_t                req,
	output logic [$clog2(BUCKETS)-1:0]         req_bucket
);
	import chte_pkg::*;

	localparam int BW = $clog2(BUCKETS);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_HASH = 4'b0010,
		F_MOD  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t          state_q;
	chte_req_t        req_q;
	logic [KEY_W-1:0] h_q, h_next;
	logic [2:0]       byte_q;
	logic [3:0]       nb_q;
	logic [3:0]       step_q;
	logic [CNT_W-1:0] div_q, rem_q, rem_next, cnt_eff;
	logic [CNT_W+BW-1:0] bucket_wide;
	logic             accept;

	assign in_stall  = (state_q != F_IDLE) || table_busy;
	assign accept    = in_valid && !in_stall;
	assign req_valid = (state_q == F_PUSH);
	assign req       = req_q;

	assign bucket_wide = {{BW{1'b0}}, rem_q};
	assign req_bucket  = bucket_wide[BW-1:0];

	always_comb begin
		if (bucket_count == '0)
			cnt_eff = CNT_W'(1);
		else if (32'(bucket_count) > 32'(BUCKETS))
			cnt_eff = CNT_W'(BUCKETS);
		else
			cnt_eff = bucket_count;
	end

	// h * prime, then xor in the next byte
	assign h_next = ((h_q << FNV_SHIFT) + (h_q * KEY_W'(FNV_LOW)))
		^ {56'd0, req_q.key[{byte_q, 3'b000} +: 8]};

	// restoring remainder, four hash bits per cycle, MSB first
	always_comb begin
		logic [CNT_W:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < 4; i++) begin
			r = {r[CNT_W-1:0], h_q[KEY_W-1-i]};
			if (r >= {1'b0, div_q})
				r = r - {1'b0, div_q};
		end
		rem_next = r[CNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					req_q.action <= action_t'(action);
					req_q.key    <= key;
					req_q.value  <= value;
					h_q          <= FNV_START;
					byte_q       <= '0;
					nb_q         <= bytes_in_use(key_bytes);
					div_q        <= cnt_eff;
					rem_q        <= '0;
					step_q       <= '0;
				end
			end
			F_HASH: begin
				h_q    <= h_next;
				byte_q <= byte_q + 1'b1;
			end
			F_MOD: begin
				rem_q  <= rem_next;
				h_q    <= h_q << 4;
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept)
						state_q <= (action_t'(action) == ACT_NONE) ? F_PUSH : F_HASH;
				end
				F_HASH: begin
					if ({1'b0, byte_q} == nb_q - 4'd1)
						state_q <= F_MOD;
				end
				F_MOD: begin
					if (step_q == 4'd15)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (req_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/chte_back.sv
// ----------------------------------------------------------------------------
// chte_back
// Chain walker: owns the bucket head, key, value and link memories, the
// free list and the result register. Clears the bucket heads after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chained_hash_table_engine_unit_assert.svh"
module chte_back #(
	parameter int BUCKETS = 1024,
	parameter int NODES   = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  chte_pkg::chte_req_t        req,
	input  logic [$clog2(BUCKETS)-1:0] req_bucket,
	input  logic [chte_pkg::KB_W-1:0]  key_bytes,
	output logic                       table_busy,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [chte_pkg::VAL_W-1:0] data_out,
	output logic                       status
);
	import chte_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int AW = $clog2(NODES);
	localparam int NW = $clog2(NODES + 1);
	localparam logic [NW-1:0] NIL = NW'(NODES);

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_HEAD  = 5'b00010,
		B_NODE  = 5'b00100,
		B_ALLOC = 5'b01000,
		B_POP2  = 5'b10000
	} bstate_t;

	bstate_t          state_q;
	logic             clr_q;
	logic [BW-1:0]    clr_idx_q;
	action_t          act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [BW-1:0]    bkt_q;
	logic [NW-1:0]    cur_q, prev_q, head_q, free_q, fresh_q;
	logic             out_v_q, found_q, status_q;
	logic [VAL_W-1:0] data_q;

	logic             head_we;
	logic [BW-1:0]    head_wa;
	logic [NW-1:0]    head_wd, head_rd;
	logic [AW-1:0]    node_ra, node_wa, link_wa;
	logic             node_we, link_we;
	logic [NW-1:0]    link_wd, link_rd;
	logic [KEY_W-1:0] key_rd, mask;
	logic [VAL_W-1:0] val_rd;
	logic             start, hit_now, miss_now, go_alloc, alloc_fresh, pool_full;

	assign table_busy = clr_q;
	assign req_ready  = (state_q == B_IDLE) && !clr_q && !out_v_q;
	assign start      = req_valid && req_ready;
	assign mask       = key_mask(key_bytes);

	assign hit_now  = (state_q == B_NODE) && ((key_rd & mask) == (key_q & mask));
	assign miss_now = ((state_q == B_HEAD) && (head_rd == NIL))
		|| ((state_q == B_NODE) && !hit_now && (link_rd == NIL));
	assign go_alloc    = miss_now && (act_q == ACT_SET) && (free_q != NIL);
	assign alloc_fresh = miss_now && (act_q == ACT_SET) && (free_q == NIL)
		&& (fresh_q != NIL);
	assign pool_full   = miss_now && (act_q == ACT_SET) && (free_q == NIL)
		&& (fresh_q == NIL);

	always_comb begin
		head_we = 1'b0;
		head_wa = bkt_q;
		head_wd = NIL;
		node_we = 1'b0;
		node_wa = cur_q[AW-1:0];
		link_we = 1'b0;
		link_wa = cur_q[AW-1:0];
		link_wd = head_q;
		node_ra = cur_q[AW-1:0];
		case (state_q)
			B_IDLE: begin
				if (clr_q) begin
					head_we = 1'b1;
					head_wa = clr_idx_q;
				end
			end
			B_HEAD: node_ra = head_rd[AW-1:0];
			B_NODE: begin
				if (hit_now) begin
					if (act_q == ACT_SET) begin
						node_we = 1'b1;
					end else if (act_q == ACT_POP) begin
						if (prev_q != NIL) begin
							link_we = 1'b1;
							link_wa = prev_q[AW-1:0];
							link_wd = link_rd;
						end else begin
							head_we = 1'b1;
							head_wd = link_rd;
						end
					end
				end else begin
					node_ra = link_rd[AW-1:0];
				end
			end
			B_ALLOC: begin
				// link_rd holds the next recycled node
				node_we = 1'b1;
				node_wa = free_q[AW-1:0];
				link_we = 1'b1;
				link_wa = free_q[AW-1:0];
				link_wd = head_q;
				head_we = 1'b1;
				head_wd = free_q;
			end
			B_POP2: begin
				link_we = 1'b1;
				link_wd = free_q;
			end
			default: ;
		endcase
		if (go_alloc)
			node_ra = free_q[AW-1:0];
		if (alloc_fresh) begin
			// chain is empty on a miss from the head, so NIL is the old head
			node_we = 1'b1;
			node_wa = fresh_q[AW-1:0];
			link_we = 1'b1;
			link_wa = fresh_q[AW-1:0];
			link_wd = (state_q == B_HEAD) ? NIL : head_q;
			head_we = 1'b1;
			head_wd = fresh_q;
		end
	end

	chte_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_wa),
		.wdata (head_wd),
		.raddr (req_bucket),
		.rdata (head_rd)
	);

	chte_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_wa),
		.wdata (key_q),
		.raddr (node_ra),
		.rdata (key_rd)
	);

	chte_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_wa),
		.wdata (val_q),
		.raddr (node_ra),
		.rdata (val_rd)
	);

	chte_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_wa),
		.wdata (link_wd),
		.raddr (node_ra),
		.rdata (link_rd)
	);

	always_ff @(posedge clk) begin
		if (start) begin
			act_q <= req.action;
			key_q <= req.key;
			val_q <= req.value;
			bkt_q <= req_bucket;
		end
		if (state_q == B_HEAD) begin
			head_q <= head_rd;
			cur_q  <= head_rd;
			prev_q <= NIL;
		end
		if (state_q == B_NODE && !hit_now) begin
			prev_q <= cur_q;
			cur_q  <= link_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			free_q    <= NIL;
			fresh_q   <= '0;
			out_v_q   <= 1'b0;
			found_q   <= 1'b0;
			data_q    <= '0;
			status_q  <= 1'b0;
		end else begin
			if (out_v_q && !out_stall)
				out_v_q <= 1'b0;
			if (miss_now && !go_alloc) begin
				out_v_q  <= 1'b1;
				found_q  <= 1'b0;
				data_q   <= '0;
				status_q <= pool_full;
				state_q  <= B_IDLE;
			end
			if (alloc_fresh)
				fresh_q <= fresh_q + 1'b1;
			case (state_q)
				B_IDLE: begin
					if (clr_q) begin
						clr_idx_q <= clr_idx_q + 1'b1;
						if (clr_idx_q == BW'(BUCKETS - 1))
							clr_q <= 1'b0;
					end else if (start) begin
						if (req.action == ACT_NONE) begin
							out_v_q  <= 1'b1;
							found_q  <= 1'b0;
							data_q   <= '0;
							status_q <= 1'b0;
						end else begin
							state_q <= B_HEAD;
						end
					end
				end
				B_HEAD: begin
					if (head_rd != NIL)
						state_q <= B_NODE;
				end
				B_NODE: begin
					if (hit_now) begin
						out_v_q  <= 1'b1;
						found_q  <= 1'b1;
						data_q   <= val_rd;
						status_q <= 1'b0;
						state_q  <= (act_q == ACT_POP) ? B_POP2 : B_IDLE;
					end
					if (go_alloc)
						state_q <= B_ALLOC;
				end
				B_ALLOC: begin
					free_q   <= link_rd;
					out_v_q  <= 1'b1;
					found_q  <= 1'b0;
					data_q   <= '0;
					status_q <= 1'b0;
					state_q  <= B_IDLE;
				end
				B_POP2: begin
					free_q  <= cur_q;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_HEAD && go_alloc)
				state_q <= B_ALLOC;
		end
	end

	assign out_valid = out_v_q;
	assign found     = found_q;
	assign data_out  = data_q;
	assign status    = status_q;

	`CHTE_NEVER(a_idle_while_clearing, clk, arst_n, clr_q && (state_q != B_IDLE))
	`CHTE_NEVER(a_fresh_in_range, clk, arst_n, fresh_q > NIL)
	`CHTE_ASSERT(a_walk_on_node, clk, arst_n, (state_q == B_NODE) |-> (cur_q != NIL))
	`CHTE_ASSERT(a_pop_frees_node, clk, arst_n, (state_q == B_POP2) |=> (free_q == $past(cur_q)))

endmodule

FILE: sv/chained_hash_table_engine_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_unit
// Key/value table with separate chaining, FNV-1 bucket hash, node pool.
//
// Channel   Handshake                  Payload
// in        in_valid / in_stall        action, key, value
// out       out_valid / out_stall      found, data_out, status
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// The front end steps through F_IDLE, F_HASH (one hash byte per cycle),
// F_MOD (four remainder bits per cycle) and F_PUSH; the unused action skips
// to F_PUSH. The walker reads the bucket head in B_HEAD, visits nodes in
// B_NODE, then links a recycled node in B_ALLOC or frees a popped one in
// B_POP2. The walker takes no new request while its result waits on
// out_stall. After reset the bucket head memory is cleared, one bucket per
// cycle; in_stall stays high meanwhile. A two-entry request queue lets
// hashing of the next action overlap the chain walk of this one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module chained_hash_table_engine_unit #(
	parameter int BUCKETS = 1024,
	parameter int NODES   = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [chte_pkg::ACT_W-1:0]     action,
	input  logic [chte_pkg::KEY_W-1:0]     key,
	input  logic [chte_pkg::VAL_W-1:0]     value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [chte_pkg::VAL_W-1:0]     data_out,
	output logic                           status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [chte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [chte_pkg::CNT_W-1:0]     cfg_data
);
	import chte_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int QW = $bits(chte_req_t) + BW;

	logic [CNT_W-1:0] bucket_count_q;
	logic [KB_W-1:0]  key_bytes_q;
	logic             table_busy;
	logic             f_valid, f_ready, b_valid, b_ready;
	chte_req_t        f_req, b_req;
	logic [BW-1:0]    f_bucket, b_bucket;
	logic [QW-1:0]    q_in, q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CNT_W'(1024);
			key_bytes_q    <= KB_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BUCKET_COUNT: bucket_count_q <= cfg_data;
				REG_KEY_BYTES:    key_bytes_q    <= cfg_data[KB_W-1:0];
				default: ;
			endcase
		end
	end

	chte_front #(.BUCKETS(BUCKETS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.key          (key),
		.value        (value),
		.bucket_count (bucket_count_q),
		.key_bytes    (key_bytes_q),
		.table_busy   (table_busy),
		.req_valid    (f_valid),
		.req_ready    (f_ready),
		.req          (f_req),
		.req_bucket   (f_bucket)
	);

	assign q_in = {f_req, f_bucket};
	assign b_req    = q_out[QW-1:BW];
	assign b_bucket = q_out[BW-1:0];

	chte_fifo #(.WIDTH(QW), .DEPTH(2)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_in),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_out)
	);

	chte_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (b_valid),
		.req_ready  (b_ready),
		.req        (b_req),
		.req_bucket (b_bucket),
		.key_bytes  (key_bytes_q),
		.table_busy (table_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.data_out   (data_out),
		.status     (status)
	);

endmodule
